// ===== rtl/core/sfd_pkg.sv =====
// Shared types and constants for the stuffed frame deframer.
package sfd_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'hAA;
  localparam logic [7:0] HDR_BYTE   = 8'h11;
  localparam logic [7:0] END_BYTE   = 8'h22;
  localparam logic [7:0] STUFF_BYTE = 8'h33;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;
  localparam logic [1:0] KIND_ABORT   = 2'd3;

  localparam int LEN_W       = 12;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_GOT_AA,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  typedef enum logic [2:0] {
    OP_DATA,
    OP_CHECK,
    OP_CHECK_LAST,
    OP_START,
    OP_ABORT,
    OP_ABORT_START
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } op_word_t;

endpackage

// ===== rtl/core/stuffed_frame_deframer.sv =====
// Top level of the stuffed frame deframer.
//
//   channel   handshake             payload
//   in_       in_push / in_full     in_rx_byte
//   out_      out_pop / out_empty   out_kind, out_payload_byte, out_payload_length,
//                                   out_bad_frame_count
//   cfg_      cfg_valid / cfg_ready cfg_version_offset
//
// Sustains one byte per cycle while in_full stays low. A result reaches the out_ ports
// after its byte is taken through the queue write, then checksum stage 1 (byte product),
// then stage 2 (weighted sum and compare) into the result register. A 4-word queue
// sits between front and back; in_full rises once it fills while out_pop is held low.
// cfg_ready is always high. Synchronous reset, no clearing pass.
module stuffed_frame_deframer #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [11:0] out_payload_length,
  output logic [31:0] out_bad_frame_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_version_offset
);

  sfd_pkg::op_word_t front_word, head_word;
  logic              front_push, q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  sfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (front_push),
    .q_word     (front_word)
  );

  sfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_word (front_word),
    .full      (q_full),
    .pop       (q_pop),
    .head_word (head_word),
    .empty     (q_empty)
  );

  sfd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_word              (head_word),
    .q_pop               (q_pop),
    .cfg_valid           (cfg_valid & cfg_ready),
    .cfg_version_offset  (cfg_version_offset),
    .out_pop             (out_pop),
    .out_empty           (out_empty),
    .out_kind            (out_kind),
    .out_payload_byte    (out_payload_byte),
    .out_payload_length  (out_payload_length),
    .out_bad_frame_count (out_bad_frame_count)
  );

endmodule

// ===== rtl/core/sfd_front.sv =====
// Front end: header/escape tracking, raw length limit, byte classification.
module sfd_front #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic [7:0]       in_rx_byte,
  input  logic             q_full,
  output logic             q_push,
  output sfd_pkg::op_word_t q_word
);

  localparam int RAW_LIMIT = 2 * MAX_PAYLOAD + 10;
  localparam int RAW_W     = $clog2(RAW_LIMIT + 1);
  localparam logic [RAW_W-1:0] RAW_LIM = RAW_W'(RAW_LIMIT);

  sfd_pkg::phase_t  phase_r, phase_nxt;
  logic [RAW_W-1:0] raw_r, raw_nxt;
  logic             esc_r, esc_nxt;
  logic [1:0]       cb_r, cb_nxt;

  logic       accept;
  logic       over_lim;
  logic [7:0] b;

  assign accept   = in_push & ~q_full;
  assign b        = in_rx_byte;
  assign over_lim = ((phase_r == sfd_pkg::PH_PAYLOAD) || (phase_r == sfd_pkg::PH_CHECK))
                    && (raw_r >= RAW_LIM);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (over_lim) begin
        phase_nxt = (b == sfd_pkg::ESC_BYTE) ? sfd_pkg::PH_GOT_AA : sfd_pkg::PH_HUNT;
      end else begin
        unique case (phase_r)
          sfd_pkg::PH_HUNT: begin
            if (b == sfd_pkg::ESC_BYTE) phase_nxt = sfd_pkg::PH_GOT_AA;
          end
          sfd_pkg::PH_GOT_AA: begin
            phase_nxt = (b == sfd_pkg::HDR_BYTE) ? sfd_pkg::PH_PAYLOAD : sfd_pkg::PH_HUNT;
          end
          sfd_pkg::PH_PAYLOAD: begin
            if (esc_r) begin
              priority if (b == sfd_pkg::END_BYTE) phase_nxt = sfd_pkg::PH_CHECK;
              else if (b == sfd_pkg::HDR_BYTE)     phase_nxt = sfd_pkg::PH_PAYLOAD;
              else if (b == sfd_pkg::STUFF_BYTE)   phase_nxt = sfd_pkg::PH_PAYLOAD;
              else                                 phase_nxt = sfd_pkg::PH_HUNT;
            end
          end
          sfd_pkg::PH_CHECK: begin
            if (cb_r == 2'd3) phase_nxt = sfd_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  // counters, escape flag and the word handed to the back end
  always_comb begin
    raw_nxt      = raw_r;
    esc_nxt      = esc_r;
    cb_nxt       = cb_r;
    q_push       = 1'b0;
    q_word.op    = sfd_pkg::OP_DATA;
    q_word.data  = b;
    if (accept) begin
      if (over_lim) begin
        q_push    = 1'b1;
        q_word.op = sfd_pkg::OP_ABORT;
        raw_nxt   = (b == sfd_pkg::ESC_BYTE) ? RAW_W'(1) : '0;
        esc_nxt   = 1'b0;
        cb_nxt    = 2'd0;
      end else begin
        unique case (phase_r)
          sfd_pkg::PH_HUNT: begin
            raw_nxt = (b == sfd_pkg::ESC_BYTE) ? RAW_W'(1) : '0;
            esc_nxt = 1'b0;
            cb_nxt  = 2'd0;
          end
          sfd_pkg::PH_GOT_AA: begin
            esc_nxt = 1'b0;
            cb_nxt  = 2'd0;
            if (b == sfd_pkg::HDR_BYTE) begin
              raw_nxt   = RAW_W'(2);
              q_push    = 1'b1;
              q_word.op = sfd_pkg::OP_START;
            end else begin
              raw_nxt = '0;
            end
          end
          sfd_pkg::PH_PAYLOAD: begin
            raw_nxt = raw_r + RAW_W'(1);
            esc_nxt = 1'b0;
            if (!esc_r) begin
              if (b == sfd_pkg::ESC_BYTE) begin
                esc_nxt = 1'b1;
              end else begin
                q_push    = 1'b1;
                q_word.op = sfd_pkg::OP_DATA;
              end
            end else begin
              priority if (b == sfd_pkg::STUFF_BYTE) begin
                q_push      = 1'b1;
                q_word.op   = sfd_pkg::OP_DATA;
                q_word.data = sfd_pkg::ESC_BYTE;
              end else if (b == sfd_pkg::END_BYTE) begin
                cb_nxt = 2'd0;
              end else if (b == sfd_pkg::HDR_BYTE) begin
                // restart inside a frame: abort old one, new frame opens now
                raw_nxt   = RAW_W'(2);
                cb_nxt    = 2'd0;
                q_push    = 1'b1;
                q_word.op = sfd_pkg::OP_ABORT_START;
              end else begin
                raw_nxt   = '0;
                cb_nxt    = 2'd0;
                q_push    = 1'b1;
                q_word.op = sfd_pkg::OP_ABORT;
              end
            end
          end
          sfd_pkg::PH_CHECK: begin
            q_push = 1'b1;
            esc_nxt = 1'b0;
            if (cb_r == 2'd3) begin
              q_word.op = sfd_pkg::OP_CHECK_LAST;
              raw_nxt   = '0;
              cb_nxt    = 2'd0;
            end else begin
              q_word.op = sfd_pkg::OP_CHECK;
              raw_nxt   = raw_r + RAW_W'(1);
              cb_nxt    = cb_r + 2'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sfd_pkg::PH_HUNT;
      raw_r   <= '0;
      esc_r   <= 1'b0;
      cb_r    <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      raw_r   <= raw_nxt;
      esc_r   <= esc_nxt;
      cb_r    <= cb_nxt;
    end
  end

endmodule

// ===== rtl/core/sfd_queue.sv =====
// Short word queue between the front and back ends.
module sfd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfd_pkg::op_word_t push_word,
  output logic              full,
  input  logic              pop,
  output sfd_pkg::op_word_t head_word,
  output logic              empty
);

  localparam int PTR_W = $clog2(sfd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(sfd_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(sfd_pkg::QUEUE_DEPTH);

  sfd_pkg::op_word_t mem_r [sfd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign empty     = (cnt_r == '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & ~empty;
  assign head_word = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/sfd_back.sv =====
// Back end: checksum accumulation, final compare, bad count, result register.
module sfd_back #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  sfd_pkg::op_word_t q_word,
  output logic              q_pop,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_version_offset,
  input  logic              out_pop,
  output logic              out_empty,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_payload_byte,
  output logic [11:0]       out_payload_length,
  output logic [31:0]       out_bad_frame_count
);

  localparam int IDX_W = $clog2(2 * MAX_PAYLOAD + 10 + 1);

  typedef struct packed {
    sfd_pkg::op_t                op;
    logic [7:0]                  data;
    logic [15:0]                 prod;
    logic [15:0]                 mult;
    logic [sfd_pkg::LEN_W-1:0]   len;
    logic [15:0]                 low;
    logic [31:0]                 rx_check;
  } s1_t;

  logic [31:0]      ver_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       xor_r, xor_nxt, sum_r, sum_nxt;
  logic [31:0]      rc_r, rc_nxt;
  s1_t              s1_r, s1_nxt;
  logic             s1_v_r;
  logic [15:0]      weight_r, weight_nxt;
  logic [31:0]      bad_r, bad_nxt;
  logic             out_v_r;
  logic [1:0]       kind_nxt;

  logic             s1_emit, s1_move;
  logic [8:0]       b1, b2;
  logic [17:0]      prod_full;
  logic [31:0]      prod_w;
  logic [31:0]      computed;

  // stage 1: index, xor, sum, received check; first product
  assign b1        = {1'b0, q_word.data} + 9'd1;
  assign b2        = {1'b0, q_word.data} + 9'd2;
  assign prod_full = b1 * b2;

  always_comb begin
    unique case (s1_r.op)
      sfd_pkg::OP_DATA, sfd_pkg::OP_CHECK_LAST,
      sfd_pkg::OP_ABORT, sfd_pkg::OP_ABORT_START: s1_emit = 1'b1;
      default:                                      s1_emit = 1'b0;
    endcase
  end

  assign s1_move   = s1_v_r & (~s1_emit | ~out_v_r | out_pop);
  assign q_pop     = ~q_empty & (~s1_v_r | s1_move);

  always_comb begin
    idx_nxt         = idx_r;
    xor_nxt         = xor_r;
    sum_nxt         = sum_r;
    rc_nxt          = rc_r;
    s1_nxt.op       = q_word.op;
    s1_nxt.data     = q_word.data;
    s1_nxt.prod     = prod_full[15:0];
    s1_nxt.mult     = 16'(idx_r) + 16'd3;
    s1_nxt.len      = sfd_pkg::LEN_W'(idx_r);
    s1_nxt.low      = {sum_r, xor_r};
    s1_nxt.rx_check = {q_word.data, rc_r[31:8]};
    unique case (q_word.op)
      sfd_pkg::OP_DATA: begin
        idx_nxt    = idx_r + IDX_W'(1);
        xor_nxt    = xor_r ^ q_word.data;
        sum_nxt    = sum_r + q_word.data + 8'd1;
        s1_nxt.len = sfd_pkg::LEN_W'(idx_nxt);
      end
      sfd_pkg::OP_CHECK, sfd_pkg::OP_CHECK_LAST: begin
        rc_nxt = {q_word.data, rc_r[31:8]};
      end
      sfd_pkg::OP_START, sfd_pkg::OP_ABORT_START: begin
        idx_nxt = '0;
        xor_nxt = 8'd0;
        sum_nxt = 8'd0;
      end
      default: begin
      end
    endcase
  end

  // stage 2: weighted sum, compare, result word
  assign prod_w   = s1_r.prod * s1_r.mult;
  assign computed = {weight_r, s1_r.low} + ver_r;

  always_comb begin
    weight_nxt = weight_r;
    bad_nxt    = bad_r;
    kind_nxt   = sfd_pkg::KIND_ABORT;
    unique case (s1_r.op)
      sfd_pkg::OP_DATA: begin
        weight_nxt = weight_r + prod_w[15:0];
        kind_nxt   = sfd_pkg::KIND_PAYLOAD;
      end
      sfd_pkg::OP_CHECK_LAST: begin
        if (computed == s1_r.rx_check) begin
          kind_nxt = sfd_pkg::KIND_GOOD;
        end else begin
          kind_nxt = sfd_pkg::KIND_BAD;
          bad_nxt  = bad_r + 32'd1;
        end
      end
      sfd_pkg::OP_START, sfd_pkg::OP_ABORT_START: begin
        weight_nxt = 16'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) s1_r <= s1_nxt;
    if (s1_move && s1_emit) begin
      out_kind            <= kind_nxt;
      out_payload_byte    <= (s1_r.op == sfd_pkg::OP_DATA) ? s1_r.data : 8'd0;
      out_payload_length  <= s1_r.len;
      out_bad_frame_count <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r    <= 32'd0;
      idx_r    <= '0;
      xor_r    <= 8'd0;
      sum_r    <= 8'd0;
      rc_r     <= 32'd0;
      s1_v_r   <= 1'b0;
      weight_r <= 16'd0;
      bad_r    <= 32'd0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_valid) ver_r <= cfg_version_offset;
      if (q_pop) begin
        idx_r <= idx_nxt;
        xor_r <= xor_nxt;
        sum_r <= sum_nxt;
        rc_r  <= rc_nxt;
      end
      if (q_pop)        s1_v_r <= 1'b1;
      else if (s1_move) s1_v_r <= 1'b0;
      if (s1_move) begin
        weight_r <= weight_nxt;
        bad_r    <= bad_nxt;
      end
      if (s1_move && s1_emit) out_v_r <= 1'b1;
      else if (out_pop)       out_v_r <= 1'b0;
    end
  end

  assign out_empty = ~out_v_r;

endmodule

// ===== rtl/core/sfd_checker.sv =====
// Port-level checks for the stuffed frame deframer, bound to the top level.
module sfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_payload_byte,
  input logic [11:0] out_payload_length,
  input logic [31:0] out_bad_frame_count
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_kind)
      && $stable(out_payload_byte) && $stable(out_payload_length)
      && $stable(out_bad_frame_count))
    else $error("result word changed while stalled");

  // reset leaves no word waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // end-of-frame words carry no byte
  a_end_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_kind != sfd_pkg::KIND_PAYLOAD |-> out_payload_byte == 8'd0)
    else $error("end word with non-zero byte");

  // the bad count only moves with a bad checksum word
  a_bad_count: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop ##1 !out_empty && out_kind != sfd_pkg::KIND_BAD
      |-> out_bad_frame_count == $past(out_bad_frame_count))
    else $error("bad count moved without a bad checksum");

endmodule

bind stuffed_frame_deframer sfd_checker u_sfd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_empty           (out_empty),
  .out_pop             (out_pop),
  .out_kind            (out_kind),
  .out_payload_byte    (out_payload_byte),
  .out_payload_length  (out_payload_length),
  .out_bad_frame_count (out_bad_frame_count)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the stuffed frame deframer: frames in, words out.
module tb;

  localparam int MAX_PAYLOAD  = 1024;
  localparam int RAW_LIMIT    = 2 * MAX_PAYLOAD + 10;
  localparam int DRAIN_CYCLES = 12;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [11:0] len;
    logic [31:0] bad;
  } rx_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic [11:0] out_payload_length;
  logic [31:0] out_bad_frame_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_version_offset = 32'h0;

  stuffed_frame_deframer #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_rx_byte          (in_rx_byte),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_kind            (out_kind),
    .out_payload_byte    (out_payload_byte),
    .out_payload_length  (out_payload_length),
    .out_bad_frame_count (out_bad_frame_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_version_offset  (cfg_version_offset)
  );

  always #4 clk = ~clk;

  // Deframer state as the bench sees it
  sfd_pkg::phase_t ph = sfd_pkg::PH_HUNT;
  int unsigned raw_cnt = 0;
  int unsigned pay_idx = 0;
  int unsigned chk_seen = 0;
  logic [7:0]  xor_acc = 8'h0;
  logic [7:0]  sum_acc = 8'h0;
  logic [15:0] wsum_acc = 16'h0;
  logic [31:0] rx_check = 32'h0;
  logic [31:0] bad_cnt = 32'h0;
  logic [31:0] ver_off = 32'h0;
  logic        esc_pending = 1'b0;

  rx_word_t    awaited_words[$];
  bit          gaps_on = 1'b1;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned kind_count[4] = '{0, 0, 0, 0};

  function automatic logic [15:0] weight_term(input logic [7:0] b, input int unsigned idx);
    logic [31:0] prod;
    prod = (32'(b) + 1) * (32'(b) + 2) * ((idx + 3) & 32'hFFFF);
    return prod[15:0];
  endfunction

  function automatic logic [31:0] frame_sum(input byte_q_t body);
    logic [7:0]  x;
    logic [7:0]  s;
    logic [15:0] w;
    x = 8'h0;
    s = 8'h0;
    w = 16'h0;
    foreach (body[i]) begin
      x = x ^ body[i];
      s = s + body[i] + 8'd1;
      w = w + weight_term(body[i], i);
    end
    return {w, s, x} + ver_off;
  endfunction

  function automatic logic [7:0] line_byte();
    case ($urandom_range(0, 9))
      0: return sfd_pkg::ESC_BYTE;
      1: return sfd_pkg::HDR_BYTE;
      2: return sfd_pkg::END_BYTE;
      3: return sfd_pkg::STUFF_BYTE;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic byte_q_t random_body(input int unsigned max_len);
    byte_q_t q;
    repeat ($urandom_range(0, max_len)) q.push_back(line_byte());
    return q;
  endfunction

  task automatic emit(input logic [1:0] k, input logic [7:0] d);
    rx_word_t w;
    w.kind = k;
    w.data = d;
    w.len  = 12'(pay_idx);
    w.bad  = bad_cnt;
    awaited_words.push_back(w);
  endtask

  task automatic enter_hunt();
    ph          = sfd_pkg::PH_HUNT;
    raw_cnt     = 0;
    esc_pending = 1'b0;
    chk_seen    = 0;
  endtask

  task automatic hunt_on(input logic [7:0] b);
    if (b == sfd_pkg::ESC_BYTE) begin
      ph      = sfd_pkg::PH_GOT_AA;
      raw_cnt = 1;
    end else begin
      enter_hunt();
    end
  endtask

  task automatic open_frame();
    ph          = sfd_pkg::PH_PAYLOAD;
    raw_cnt     = 2;
    pay_idx     = 0;
    xor_acc     = 8'h0;
    sum_acc     = 8'h0;
    wsum_acc    = 16'h0;
    rx_check    = 32'h0;
    chk_seen    = 0;
    esc_pending = 1'b0;
  endtask

  task automatic take_payload(input logic [7:0] b);
    wsum_acc = wsum_acc + weight_term(b, pay_idx);
    xor_acc  = xor_acc ^ b;
    sum_acc  = sum_acc + b + 8'd1;
    pay_idx  = pay_idx + 1;
    emit(sfd_pkg::KIND_PAYLOAD, b);
  endtask

  // Works out the words one accepted line byte should produce
  task automatic decode_rx_byte(input logic [7:0] b);
    logic [31:0] computed;
    if ((ph == sfd_pkg::PH_PAYLOAD || ph == sfd_pkg::PH_CHECK) && raw_cnt >= RAW_LIMIT) begin
      emit(sfd_pkg::KIND_ABORT, 8'h00);
      enter_hunt();
      hunt_on(b);
    end else begin
      case (ph)
        sfd_pkg::PH_HUNT: hunt_on(b);
        sfd_pkg::PH_GOT_AA: begin
          if (b == sfd_pkg::HDR_BYTE) open_frame();
          else enter_hunt();
        end
        sfd_pkg::PH_PAYLOAD: begin
          raw_cnt++;
          if (!esc_pending) begin
            if (b == sfd_pkg::ESC_BYTE) esc_pending = 1'b1;
            else take_payload(b);
          end else begin
            esc_pending = 1'b0;
            if (b == sfd_pkg::STUFF_BYTE) begin
              take_payload(sfd_pkg::ESC_BYTE);
            end else if (b == sfd_pkg::END_BYTE) begin
              ph       = sfd_pkg::PH_CHECK;
              chk_seen = 0;
              rx_check = 32'h0;
            end else begin
              emit(sfd_pkg::KIND_ABORT, 8'h00);
              if (b == sfd_pkg::HDR_BYTE) open_frame();
              else enter_hunt();
            end
          end
        end
        default: begin
          raw_cnt++;
          // check bytes are raw, little-endian
          rx_check = rx_check | (32'(b) << ((chk_seen % 4) * 8));
          chk_seen++;
          if (chk_seen >= 4) begin
            computed = {wsum_acc, sum_acc, xor_acc} + ver_off;
            if (computed == rx_check) begin
              emit(sfd_pkg::KIND_GOOD, 8'h00);
            end else begin
              bad_cnt = bad_cnt + 32'd1;
              emit(sfd_pkg::KIND_BAD, 8'h00);
            end
            enter_hunt();
          end
        end
      endcase
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push    <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    bytes_sent++;
    decode_rx_byte(b);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_push <= 1'b0;
  endtask

  task automatic send_frame(input byte_q_t body, input bit spoil);
    logic [31:0] chk;
    chk = frame_sum(body);
    if (spoil) chk = chk ^ (32'h1 << $urandom_range(0, 31));
    push_byte(sfd_pkg::ESC_BYTE);
    push_byte(sfd_pkg::HDR_BYTE);
    foreach (body[i]) begin
      push_byte(body[i]);
      if (body[i] == sfd_pkg::ESC_BYTE) push_byte(sfd_pkg::STUFF_BYTE);
    end
    push_byte(sfd_pkg::ESC_BYTE);
    push_byte(sfd_pkg::END_BYTE);
    for (int k = 0; k < 4; k++) push_byte(chk[8*k +: 8]);
  endtask

  // Only written once the pipe has drained
  task automatic set_version(input logic [31:0] v);
    release_input();
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_version_offset <= v;
    do @(posedge clk); while (!cfg_ready);
    ver_off = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    byte_q_t body;
    set_version(32'h1234_5678);
    body = {};
    send_frame(body, 1'b0);
    body = {8'h00, 8'hFF, sfd_pkg::ESC_BYTE, sfd_pkg::STUFF_BYTE, sfd_pkg::HDR_BYTE,
            sfd_pkg::END_BYTE};
    send_frame(body, 1'b0);
    body = {8'h5A};
    send_frame(body, 1'b1);
    // second AA after a first one must not arm the header
    push_byte(sfd_pkg::ESC_BYTE);
    push_byte(sfd_pkg::ESC_BYTE);
    push_byte(sfd_pkg::HDR_BYTE);
    // open a frame, then restart it with a fresh header
    push_byte(sfd_pkg::ESC_BYTE);
    push_byte(sfd_pkg::HDR_BYTE);
    push_byte(8'h07);
    body = {8'h80};
    send_frame(body, 1'b0);
    // unknown escape
    push_byte(sfd_pkg::ESC_BYTE);
    push_byte(sfd_pkg::HDR_BYTE);
    push_byte(8'h01);
    push_byte(sfd_pkg::ESC_BYTE);
    push_byte(8'h44);
  endtask

  task automatic test_random_traffic(input int unsigned n_bytes, input logic [31:0] ver);
    byte_q_t     body;
    int unsigned stop_at;
    int unsigned pick;
    set_version(ver);
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        body = random_body(pick < 5 ? 120 : 16);
        send_frame(body, 1'b0);
      end else if (pick < 78) begin
        body = random_body(16);
        send_frame(body, 1'b1);
      end else if (pick < 88) begin
        // frame cut short by an arbitrary escape
        push_byte(sfd_pkg::ESC_BYTE);
        push_byte(sfd_pkg::HDR_BYTE);
        repeat ($urandom_range(0, 6)) push_byte(line_byte());
        push_byte(sfd_pkg::ESC_BYTE);
        push_byte(8'($urandom()));
      end else begin
        repeat ($urandom_range(1, 10)) push_byte(line_byte());
      end
    end
  endtask

  always @(posedge clk) begin : check_word
    rx_word_t exp_w;
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_words.size() == 0) begin
        errors++;
        $display("%0t: word with none expected: kind=%0d byte=%02h len=%0d bad=%0d",
                 $time, out_kind, out_payload_byte, out_payload_length, out_bad_frame_count);
      end else begin
        exp_w = awaited_words.pop_front();
        kind_count[exp_w.kind]++;
        if (out_kind !== exp_w.kind || out_payload_byte !== exp_w.data ||
            out_payload_length !== exp_w.len || out_bad_frame_count !== exp_w.bad) begin
          errors++;
          $display("%0t: expected kind=%0d byte=%02h len=%0d bad=%0d,",
                   $time, exp_w.kind, exp_w.data, exp_w.len, exp_w.bad,
                   " got kind=%0d byte=%02h len=%0d bad=%0d",
                   out_kind, out_payload_byte, out_payload_length, out_bad_frame_count);
        end
      end
    end
  end

  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 9) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(290, 32'h0000_0000);
    test_random_traffic(290, 32'hFFFF_FFFF);
    test_random_traffic(290, $urandom());
    gaps_on = 1'b0;
    test_random_traffic(300, $urandom());
    release_input();
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d line bytes under five version offsets, restarts and bad escapes included.",
             bytes_sent);
    $display("Checked %0d payload words, %0d good, %0d bad checksum, %0d aborted frame ends.",
             kind_count[sfd_pkg::KIND_PAYLOAD], kind_count[sfd_pkg::KIND_GOOD],
             kind_count[sfd_pkg::KIND_BAD], kind_count[sfd_pkg::KIND_ABORT]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
